// ===== rtl/dhcp_rv_pkg.sv =====
// ----------------------------------------------------------------------------
// dhcp_rv_pkg
// Shared types and constants for the DHCPv6 reply validator.
// ----------------------------------------------------------------------------
package dhcp_rv_pkg;

   // Fixed header: message type plus 24-bit transaction id
   localparam int HEADER_BYTES = 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_EXPECTED_XID   = 2'd0;
   localparam logic [1:0] CSR_CLIENT_ID_CODE = 2'd1;
   localparam logic [1:0] CSR_SERVER_ID_CODE = 2'd2;

   // Configuration reset values
   localparam logic [23:0] EXPECTED_XID_RESET   = 24'h000000;
   localparam logic [15:0] CLIENT_ID_CODE_RESET = 16'h0001;
   localparam logic [15:0] SERVER_ID_CODE_RESET = 16'h0002;

   // Parse phase
   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_OPT_HDR = 2'd1,
      PHASE_BODY    = 2'd2
   } phase_type;

   // Verdict codes
   typedef enum logic [2:0] {
      VERDICT_OK         = 3'd0,
      VERDICT_SHORT      = 3'd1,
      VERDICT_XID_BAD    = 3'd2,
      VERDICT_OVERRUN    = 3'd3,
      VERDICT_PARTIAL    = 3'd4,
      VERDICT_NO_CLIENT  = 3'd5,
      VERDICT_NO_SERVER  = 3'd6
   } verdict_type;

endpackage

// ===== rtl/dhcpv6_reply_validator_unit.sv =====
// ----------------------------------------------------------------------------
// dhcpv6_reply_validator_unit
// Byte-serial DHCPv6 reply check: transaction id compare, option TLV walk,
// client/server id detection and one verdict per message.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// req_*     in   req_tvalid/tready    tdata: data_byte[7:0]; tlast: last_byte
// rsp_*     out  rsp_tvalid/tready    tdata: is_match[0], verdict[3:1], zeros
// csr_*     in   csr_valid/ready      csr_index[1:0], csr_wdata[23:0]
//
// One byte per cycle unless the input stage stalls. A beat is held in the
// input register, the parse step runs from there into the state and result
// registers; the final beat loads the verdict into the result register.
// Reset is synchronous and active high; it restores register defaults and
// the header phase. The input stage stalls only when it holds a final beat
// while an earlier verdict still waits in the result register.
// ----------------------------------------------------------------------------
module dhcpv6_reply_validator_unit (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] is_match, [3:1] verdict, [7:4] zero
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // configuration registers
   logic [23:0] expected_xid_ff;
   logic [15:0] client_id_code_ff;
   logic [15:0] server_id_code_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;

   // parse state
   logic [1:0]            header_position_ff, header_position_in;
   dhcp_rv_pkg::phase_type parse_phase_ff,    parse_phase_in;
   logic [1:0]            opt_hdr_count_ff,   opt_hdr_count_in;
   logic [15:0]           opt_code_ff,        opt_code_in;
   logic [15:0]           body_remaining_ff,  body_remaining_in;
   logic                  xid_bad_ff,         xid_bad_in;
   logic                  overrun_ff,         overrun_in;
   logic                  seen_client_ff,     seen_client_in;
   logic                  seen_server_ff,     seen_server_in;

   // result register
   logic                    out_valid_ff;
   dhcp_rv_pkg::verdict_type verdict_ff;
   dhcp_rv_pkg::verdict_type verdict_in;

   logic        step_go;
   logic        is_short;
   logic        partial;
   logic [7:0]  want_byte;
   logic [15:0] body_dec;

   // stall a final beat while the result register is still occupied
   assign step_go    = in_valid_ff && !(in_last_ff && out_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || step_go;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, verdict_ff,
                        (verdict_ff == dhcp_rv_pkg::VERDICT_OK)};

   assign body_dec = body_remaining_ff - 16'd1;

   // pick the expected transaction id byte for this header position
   always_comb begin
      case (header_position_ff)
         2'd1:    want_byte = expected_xid_ff[23:16];
         2'd2:    want_byte = expected_xid_ff[15:8];
         2'd3:    want_byte = expected_xid_ff[7:0];
         default: want_byte = 8'h00;
      endcase
   end

   // parse step for the held beat
   always_comb begin
      header_position_in = header_position_ff;
      parse_phase_in     = parse_phase_ff;
      opt_hdr_count_in   = opt_hdr_count_ff;
      opt_code_in        = opt_code_ff;
      body_remaining_in  = body_remaining_ff;
      xid_bad_in         = xid_bad_ff;
      overrun_in         = overrun_ff;
      seen_client_in     = seen_client_ff;
      seen_server_in     = seen_server_ff;
      is_short           = 1'b0;
      partial            = 1'b0;

      case (parse_phase_ff)
         dhcp_rv_pkg::PHASE_OPT_HDR: begin
            case (opt_hdr_count_ff)
               2'd0: opt_code_in = {in_data_ff, 8'h00};
               2'd1: opt_code_in = {opt_code_ff[15:8], in_data_ff};
               2'd2: body_remaining_in = {in_data_ff, 8'h00};
               default: begin
                  body_remaining_in = {body_remaining_ff[15:8], in_data_ff};
                  if (opt_code_ff == client_id_code_ff) begin
                     seen_client_in = 1'b1;
                  end else if (opt_code_ff == server_id_code_ff) begin
                     seen_server_in = 1'b1;
                  end
               end
            endcase
            if (opt_hdr_count_ff == 2'd3) begin
               opt_hdr_count_in = 2'd0;
               if (body_remaining_in != 16'd0) begin
                  parse_phase_in = dhcp_rv_pkg::PHASE_BODY;
                  if (in_last_ff) begin
                     overrun_in = 1'b1;
                  end
               end
            end else begin
               opt_hdr_count_in = opt_hdr_count_ff + 2'd1;
               partial          = in_last_ff;
            end
         end
         dhcp_rv_pkg::PHASE_BODY: begin
            body_remaining_in = body_dec;
            if (body_dec == 16'd0) begin
               parse_phase_in = dhcp_rv_pkg::PHASE_OPT_HDR;
            end else if (in_last_ff) begin
               overrun_in = 1'b1;
            end
         end
         default: begin
            // header phase: skip message type, compare transaction id
            if (header_position_ff != 2'd0 && want_byte != in_data_ff) begin
               xid_bad_in = 1'b1;
            end
            if (header_position_ff == 2'(dhcp_rv_pkg::HEADER_BYTES - 1)) begin
               header_position_in = 2'd0;
               parse_phase_in     = dhcp_rv_pkg::PHASE_OPT_HDR;
               opt_hdr_count_in   = 2'd0;
            end else begin
               header_position_in = header_position_ff + 2'd1;
               is_short           = in_last_ff;
            end
         end
      endcase

      // first failing check wins
      if (is_short) begin
         verdict_in = dhcp_rv_pkg::VERDICT_SHORT;
      end else if (xid_bad_in) begin
         verdict_in = dhcp_rv_pkg::VERDICT_XID_BAD;
      end else if (overrun_in) begin
         verdict_in = dhcp_rv_pkg::VERDICT_OVERRUN;
      end else if (partial) begin
         verdict_in = dhcp_rv_pkg::VERDICT_PARTIAL;
      end else if (!seen_client_in) begin
         verdict_in = dhcp_rv_pkg::VERDICT_NO_CLIENT;
      end else if (!seen_server_in) begin
         verdict_in = dhcp_rv_pkg::VERDICT_NO_SERVER;
      end else begin
         verdict_in = dhcp_rv_pkg::VERDICT_OK;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_xid_ff   <= dhcp_rv_pkg::EXPECTED_XID_RESET;
         client_id_code_ff <= dhcp_rv_pkg::CLIENT_ID_CODE_RESET;
         server_id_code_ff <= dhcp_rv_pkg::SERVER_ID_CODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dhcp_rv_pkg::CSR_EXPECTED_XID:   expected_xid_ff   <= csr_wdata;
            dhcp_rv_pkg::CSR_CLIENT_ID_CODE: client_id_code_ff <= csr_wdata[15:0];
            dhcp_rv_pkg::CSR_SERVER_ID_CODE: server_id_code_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input register: take a beat when empty or whenever the held one moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // parse state: advance per beat, clear after the final beat
   always_ff @(posedge clock) begin
      if (reset || (step_go && in_last_ff)) begin
         header_position_ff <= 2'd0;
         parse_phase_ff     <= dhcp_rv_pkg::PHASE_HEADER;
         opt_hdr_count_ff   <= 2'd0;
         opt_code_ff        <= 16'h0000;
         body_remaining_ff  <= 16'h0000;
         xid_bad_ff         <= 1'b0;
         overrun_ff         <= 1'b0;
         seen_client_ff     <= 1'b0;
         seen_server_ff     <= 1'b0;
      end else if (step_go) begin
         header_position_ff <= header_position_in;
         parse_phase_ff     <= parse_phase_in;
         opt_hdr_count_ff   <= opt_hdr_count_in;
         opt_code_ff        <= opt_code_in;
         body_remaining_ff  <= body_remaining_in;
         xid_bad_ff         <= xid_bad_in;
         overrun_ff         <= overrun_in;
         seen_client_ff     <= seen_client_in;
         seen_server_ff     <= seen_server_in;
      end
   end

   // result register: load on a final beat, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_go && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && in_last_ff) begin
         verdict_ff <= verdict_in;
      end
   end

endmodule
